/* rtl/core/hid_keyboard_report_differ_macros.svh */
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ_macros.svh
// Assertion shorthands for the keyboard report differ. Both macros clock on
// clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_DIFFER_MACROS_SVH
`define HID_KEYBOARD_REPORT_DIFFER_MACROS_SVH

// Same-cycle implication.
`define HKRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HKRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hkrd_pkg.sv */
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types and constants of the keyboard report differ.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrd_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int MAP_ENTRIES = 256;
  localparam int CODE_W      = 8;
  localparam int MAP_AW      = $clog2(MAP_ENTRIES);

  localparam logic [CODE_W-1:0] CODE_DELETE = 8'h4C;
  localparam logic [7:0]        MOD_CTRL    = 8'h11;
  localparam logic [7:0]        MOD_SHIFT   = 8'h22;
  localparam logic [7:0]        MOD_ALT     = 8'h44;
  localparam logic [CODE_W-1:0] UNMAPPED    = 8'hFF;

  // back-end step schedule: head event, releases, presses, end marker
  localparam int STEP_REL = 1;
  localparam int STEP_PRS = 1 + KEY_SLOTS;
  localparam int STEP_END = 1 + 2 * KEY_SLOTS;
  localparam int STEP_W   = $clog2(STEP_END + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_REPORT     = 2'd0,
    OP_MAP_WRITE  = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_PRESS         = 3'd0,
    EV_RELEASE       = 3'd1,
    EV_SHIFT_DOWN    = 3'd2,
    EV_SHIFT_UP      = 3'd3,
    EV_MACHINE_RESET = 3'd4,
    EV_RELEASE_ALL   = 3'd5
  } ev_t;

  typedef enum logic {
    JOB_EVENTS    = 1'b0,
    JOB_MAP_WRITE = 1'b1
  } job_kind_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       modifiers;
    logic [CODE_W-1:0] key0;
    logic [CODE_W-1:0] key1;
    logic [CODE_W-1:0] key2;
    logic [CODE_W-1:0] key3;
    logic [CODE_W-1:0] key4;
    logic [CODE_W-1:0] key5;
    logic [MAP_AW-1:0] map_index;
    logic [CODE_W-1:0] map_value;
  } in_word_t;

  typedef struct packed {
    ev_t               event_res;
    logic [CODE_W-1:0] scan_code;
    logic              last;
  } out_word_t;

  typedef struct packed {
    job_kind_t                          kind;
    logic                               head_valid;
    ev_t                                head_event;
    logic [KEY_SLOTS-1:0]               rel_mask;
    logic [KEY_SLOTS-1:0][CODE_W-1:0]   rel_code;
    logic [KEY_SLOTS-1:0]               prs_mask;
    logic [KEY_SLOTS-1:0][CODE_W-1:0]   prs_code;
    logic [MAP_AW-1:0]                  map_index;
    logic [CODE_W-1:0]                  map_value;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/hkrd_front.sv */
// ----------------------------------------------------------------------------
// hkrd_front
// Accepts input words, diffs reports against the stored key state and
// turns each word into a job for the event sequencer; unused ops make none.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rpt_valid,
  output logic                   rpt_stall,
  input  wire hkrd_pkg::in_word_t rpt,
  input  wire hkrd_pkg::q_stat_t q_stat,
  output logic                   push,
  output hkrd_pkg::job_t         job
);

  logic [hkrd_pkg::KEY_SLOTS-1:0][hkrd_pkg::CODE_W-1:0] prior_codes;
  logic                                                shift_held;
  logic [hkrd_pkg::KEY_SLOTS-1:0][hkrd_pkg::CODE_W-1:0] now;
  logic [hkrd_pkg::KEY_SLOTS-1:0] rel_mask;
  logic [hkrd_pkg::KEY_SLOTS-1:0] prs_mask;
  logic accept;
  logic chord;
  logic shift;

  assign rpt_stall = q_stat.full;
  assign accept    = rpt_valid && !q_stat.full;
  assign shift     = |(rpt.modifiers & hkrd_pkg::MOD_SHIFT);

  assign now = {rpt.key5, rpt.key4, rpt.key3, rpt.key2, rpt.key1, rpt.key0};

  // key diff in both directions
  always_comb begin
    logic hit_del;
    logic in_now;
    logic in_prior;
    hit_del = 1'b0;
    for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++) begin
      hit_del = hit_del || (now[i] == hkrd_pkg::CODE_DELETE);
    end
    chord = (|(rpt.modifiers & hkrd_pkg::MOD_CTRL)) &&
            (|(rpt.modifiers & hkrd_pkg::MOD_ALT)) && hit_del;
    for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++) begin
      in_now   = 1'b0;
      in_prior = 1'b0;
      for (int j = 0; j < hkrd_pkg::KEY_SLOTS; j++) begin
        in_now   = in_now   || (now[j] == prior_codes[i]);
        in_prior = in_prior || (prior_codes[j] == now[i]);
      end
      rel_mask[i] = (prior_codes[i] != '0) && !in_now;
      prs_mask[i] = (now[i] != '0) && !in_prior;
    end
  end

  always_comb begin
    job            = '0;
    job.kind       = hkrd_pkg::JOB_EVENTS;
    job.head_event = hkrd_pkg::EV_RELEASE_ALL;
    job.rel_code   = prior_codes;
    job.prs_code   = now;
    job.map_index  = rpt.map_index;
    job.map_value  = rpt.map_value;
    push           = accept;
    unique case (rpt.op)
      hkrd_pkg::OP_REPORT: begin
        if (chord) begin
          job.head_valid = 1'b1;
          job.head_event = hkrd_pkg::EV_MACHINE_RESET;
        end else begin
          job.head_valid = (shift != shift_held);
          job.head_event = shift ? hkrd_pkg::EV_SHIFT_DOWN : hkrd_pkg::EV_SHIFT_UP;
          job.rel_mask   = rel_mask;
          job.prs_mask   = prs_mask;
        end
      end
      hkrd_pkg::OP_MAP_WRITE: begin
        job.kind = hkrd_pkg::JOB_MAP_WRITE;
      end
      hkrd_pkg::OP_DISCONNECT: begin
        job.head_valid = 1'b1;
        job.head_event = hkrd_pkg::EV_RELEASE_ALL;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_codes <= '0;
      shift_held  <= 1'b0;
    end else if (accept) begin
      if (rpt.op == hkrd_pkg::OP_DISCONNECT ||
          (rpt.op == hkrd_pkg::OP_REPORT && chord)) begin
        prior_codes <= '0;
        shift_held  <= 1'b0;
      end else if (rpt.op == hkrd_pkg::OP_REPORT) begin
        prior_codes <= now;
        shift_held  <= shift;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hkrd_queue.sv */
// ----------------------------------------------------------------------------
// hkrd_queue
// Short job FIFO between the diff front end and the event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire hkrd_pkg::job_t  push_job,
  input  wire logic            pop,
  output hkrd_pkg::job_t       head,
  output hkrd_pkg::q_stat_t    q_stat
);

  hkrd_pkg::job_t                entries [hkrd_pkg::QUEUE_DEPTH];
  logic [hkrd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [hkrd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [hkrd_pkg::QCNT_W-1:0]   count;

  localparam logic [hkrd_pkg::QPTR_W-1:0] PTR_LAST =
    hkrd_pkg::QPTR_W'(hkrd_pkg::QUEUE_DEPTH - 1);
  localparam logic [hkrd_pkg::QCNT_W-1:0] CNT_FULL =
    hkrd_pkg::QCNT_W'(hkrd_pkg::QUEUE_DEPTH);

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == CNT_FULL);
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hkrd_back.sv */
// ----------------------------------------------------------------------------
// hkrd_back
// Event sequencer: does map writes, walks event jobs slot by slot, maps key codes
// through the scan-code map and emits one event word per cycle at most.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hkrd_pkg::job_t    head,
  input  wire hkrd_pkg::q_stat_t q_stat,
  output logic                   pop,
  output logic                   evt_valid,
  input  wire logic              evt_stall,
  output hkrd_pkg::out_word_t    evt
);

  logic [hkrd_pkg::CODE_W-1:0]    map_mem [hkrd_pkg::MAP_ENTRIES];
  logic [hkrd_pkg::MAP_ENTRIES-1:0] entry_valid;
  logic [hkrd_pkg::CODE_W-1:0]    rd_data;
  logic                           rd_hit;

  logic [hkrd_pkg::STEP_W-1:0]    step;
  logic                           adv;
  logic                           busy;
  logic                           map_wr;

  // slot candidate (stage A)
  logic                           cand_valid;
  logic                           cand_end;
  logic                           cand_key;
  hkrd_pkg::ev_t                  cand_kind;
  logic [hkrd_pkg::CODE_W-1:0]    cand_code;

  // lookup result (stage B)
  logic                           s1_valid;
  logic                           s1_end;
  logic                           s1_key;
  hkrd_pkg::ev_t                  s1_kind;
  logic [hkrd_pkg::CODE_W-1:0]    looked;
  logic                           fire;
  hkrd_pkg::out_word_t            ev_word;

  // one event held back until we know whether it is the final one
  logic                           hold_valid;
  hkrd_pkg::out_word_t            hold;
  logic                           emit;
  hkrd_pkg::out_word_t            emit_word;

  assign adv    = !evt_valid || !evt_stall;
  assign busy   = !q_stat.empty;
  assign map_wr = busy && (head.kind == hkrd_pkg::JOB_MAP_WRITE);
  assign pop    = adv && busy &&
                  (head.kind == hkrd_pkg::JOB_MAP_WRITE ||
                   step == hkrd_pkg::STEP_W'(hkrd_pkg::STEP_END));

  always_comb begin
    cand_valid = 1'b0;
    cand_end   = 1'b0;
    cand_key   = 1'b0;
    cand_kind  = head.head_event;
    cand_code  = '0;
    if (busy && head.kind == hkrd_pkg::JOB_EVENTS) begin
      if (step == '0) begin
        cand_valid = head.head_valid;
      end
      for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++) begin
        if (step == hkrd_pkg::STEP_W'(hkrd_pkg::STEP_REL + i)) begin
          cand_valid = head.rel_mask[i];
          cand_kind  = hkrd_pkg::EV_RELEASE;
          cand_code  = head.rel_code[i];
          cand_key   = 1'b1;
        end
        if (step == hkrd_pkg::STEP_W'(hkrd_pkg::STEP_PRS + i)) begin
          cand_valid = head.prs_mask[i];
          cand_kind  = hkrd_pkg::EV_PRESS;
          cand_code  = head.prs_code[i];
          cand_key   = 1'b1;
        end
      end
      if (step == hkrd_pkg::STEP_W'(hkrd_pkg::STEP_END)) begin
        cand_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (adv && busy) begin
      step <= pop ? '0 : step + 1'b1;
    end
  end

  // scan-code map, registered read
  always_ff @(posedge clk) begin
    if (adv) begin
      if (map_wr) begin
        map_mem[head.map_index] <= head.map_value;
      end
      rd_data <= map_mem[cand_code];
    end
  end

  // entries never written read as unmapped
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else if (adv) begin
      if (map_wr) begin
        entry_valid[head.map_index] <= 1'b1;
      end
      rd_hit <= entry_valid[cand_code];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_end   <= 1'b0;
    end else if (adv) begin
      s1_valid <= cand_valid;
      s1_end   <= cand_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind <= cand_kind;
      s1_key  <= cand_key;
    end
  end

  assign looked = rd_hit ? rd_data : hkrd_pkg::UNMAPPED;
  assign fire   = s1_valid && (!s1_key || looked != hkrd_pkg::UNMAPPED);

  always_comb begin
    ev_word           = '0;
    ev_word.event_res = s1_kind;
    ev_word.scan_code = s1_key ? looked : '0;
    emit              = 1'b0;
    emit_word         = hold;
    if (fire && hold_valid) begin
      emit           = 1'b1;
      emit_word.last = 1'b0;
    end else if (s1_end && hold_valid) begin
      emit           = 1'b1;
      emit_word.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      evt_valid  <= 1'b0;
    end else if (adv) begin
      if (fire) begin
        hold_valid <= 1'b1;
      end else if (s1_end) begin
        hold_valid <= 1'b0;
      end
      evt_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fire) begin
        hold <= ev_word;
      end
      if (emit) begin
        evt <= emit_word;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hid_keyboard_report_differ.sv */
// Path: an accepted word is pushed into the job queue; its events then pass the slot
//   candidate, the registered map lookup and the hold register to the output word.
// Occupancy: each report or disconnect holds the event sequencer through every
//   slot step; a map write is popped at its first step.
// Input words queue two deep ahead of the sequencer; events leave at most one per cycle.
// Reset: synchronous, active high. Key state, queue and outputs clear at once;
//   the whole scan-code map reads as unmapped right after reset, no clearing pass.
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ
// Diffs boot keyboard reports against the previous one and emits a serial
// list of key events; maintains a loadable scan-code map.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_keyboard_report_differ_macros.svh"

module hid_keyboard_report_differ (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rpt_valid,
  output logic                      rpt_stall,
  input  wire hkrd_pkg::in_word_t   rpt,
  output logic                      evt_valid,
  input  wire logic                 evt_stall,
  output hkrd_pkg::out_word_t       evt
);

  // Front end: holds the previous key codes and shift state, detects the
  // Ctrl+Alt+Delete chord and builds release/press masks for the sequencer.
  // Stalls only when the job queue is full, so it keeps taking words while
  // the sequencer is still emitting events of an earlier report.
  hkrd_pkg::job_t    push_job;
  logic              push;
  hkrd_pkg::job_t    head;
  logic              pop;
  hkrd_pkg::q_stat_t q_stat;

  hkrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  // Two-entry job queue decouples the front end from the sequencer.
  hkrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Sequencer: steps through head event, releases, presses, end marker.
  // Map lookups are registered; one event is held back so the final word
  // of each job can carry last. The whole back end freezes while the
  // output word is stalled.
  hkrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  // Single-event jobs must close themselves.
  `HKRD_ASSERT_NOW(a_single_is_last,
    evt_valid && (evt.event_res == hkrd_pkg::EV_MACHINE_RESET ||
                  evt.event_res == hkrd_pkg::EV_RELEASE_ALL),
    evt.last && evt.scan_code == '0,
    "reset or release-all word without last or with a scan code")

  // Unmapped codes never produce key events.
  `HKRD_ASSERT_NOW(a_key_mapped,
    evt_valid && (evt.event_res == hkrd_pkg::EV_PRESS ||
                  evt.event_res == hkrd_pkg::EV_RELEASE),
    evt.scan_code != hkrd_pkg::UNMAPPED,
    "key event carries the unmapped code")

  // A map write always lands in the queue.
  `HKRD_ASSERT_NEXT(a_map_write_queued,
    rpt_valid && !rpt_stall && rpt.op == hkrd_pkg::OP_MAP_WRITE,
    !q_stat.empty,
    "accepted map write missing from job queue")

endmodule

`default_nettype wire

/* dv/hid_keyboard_report_differ_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ_tb
// Drives boot keyboard report words, map writes, disconnects and stray ops
// into the differ under random idling on both channels. Every accepted word
// runs through an in-bench diff engine; each event word out of the block is
// compared field by field against the oldest expected event.
// ----------------------------------------------------------------------------

module hid_keyboard_report_differ_tb;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_WORDS = 188;
  localparam int IN_W = $bits(hkrd_pkg::in_word_t);
  localparam int KS = hkrd_pkg::KEY_SLOTS;
  localparam int CW = hkrd_pkg::CODE_W;

  // how a stimulus row gets its expectation
  typedef enum logic [1:0] {
    ROW_PREDICTED,  // from the diff engine below
    ROW_NO_RESULT,  // typed in: nothing comes out
    ROW_ONE_EVENT   // typed in: one event, scan code 0, marked last
  } row_chk_t;

  typedef struct {
    hkrd_pkg::in_word_t w;
    row_chk_t           chk;
    hkrd_pkg::ev_t      one_ev;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                rpt_valid = 1'b0;
  logic                rpt_stall;
  hkrd_pkg::in_word_t  rpt = '0;
  logic                evt_valid;
  logic                evt_stall = 1'b0;
  hkrd_pkg::out_word_t evt;

  int  cycle_count = 0;
  int  err_count = 0;
  bit  quiet = 1'b0;  // set for the tail of the run: no idling anywhere
  wire calm = quiet || (cycle_count % 1536 >= 1024);

  hid_keyboard_report_differ u_dut (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Diff engine: mirrors the block's key state and scan-code map.
  // --------------------------------------------------------------------------
  logic [KS-1:0][CW-1:0] held_codes;
  logic                  shift_latched;
  logic [CW-1:0]         scan_map [hkrd_pkg::MAP_ENTRIES];
  hkrd_pkg::out_word_t   fresh_events[$];    // events of latest word
  hkrd_pkg::out_word_t   expected_events[$]; // waiting for the block

  function automatic void add_event(hkrd_pkg::ev_t kind, logic [CW-1:0] code);
    hkrd_pkg::out_word_t e;
    e.event_res = kind;
    e.scan_code = code;
    e.last      = 1'b0;
    fresh_events.push_back(e);
  endfunction

  function automatic void clear_keys();
    held_codes    = '0;
    shift_latched = 1'b0;
  endfunction

  function automatic void diff_report(hkrd_pkg::in_word_t w);
    logic [KS-1:0][CW-1:0] now_codes;
    logic                  shift_now;
    bit                    chord;
    bit                    found;
    hkrd_pkg::out_word_t   tail;
    fresh_events.delete();
    now_codes[0] = w.key0;
    now_codes[1] = w.key1;
    now_codes[2] = w.key2;
    now_codes[3] = w.key3;
    now_codes[4] = w.key4;
    now_codes[5] = w.key5;
    case (w.op)
      hkrd_pkg::OP_MAP_WRITE: begin
        scan_map[w.map_index] = w.map_value;
      end
      hkrd_pkg::OP_DISCONNECT: begin
        clear_keys();
        add_event(hkrd_pkg::EV_RELEASE_ALL, '0);
      end
      hkrd_pkg::OP_REPORT: begin
        // ctrl+alt+delete: Delete may sit in any slot, either ctrl and either alt
        chord = 1'b0;
        if ((w.modifiers & hkrd_pkg::MOD_CTRL) != 8'h00 &&
            (w.modifiers & hkrd_pkg::MOD_ALT) != 8'h00) begin
          for (int i = 0; i < KS; i++) begin
            if (now_codes[i] == hkrd_pkg::CODE_DELETE) chord = 1'b1;
          end
        end
        if (chord) begin
          clear_keys();
          add_event(hkrd_pkg::EV_MACHINE_RESET, '0);
        end else begin
          shift_now = (w.modifiers & hkrd_pkg::MOD_SHIFT) != 8'h00;
          if (shift_now && !shift_latched) add_event(hkrd_pkg::EV_SHIFT_DOWN, '0);
          if (!shift_now && shift_latched) add_event(hkrd_pkg::EV_SHIFT_UP, '0);
          shift_latched = shift_now;
          // releases: every held slot scanned, so duplicates release twice
          for (int i = 0; i < KS; i++) begin
            if (held_codes[i] != '0) begin
              found = 1'b0;
              for (int j = 0; j < KS; j++) begin
                if (now_codes[j] == held_codes[i]) found = 1'b1;
              end
              if (!found && scan_map[held_codes[i]] != hkrd_pkg::UNMAPPED) begin
                add_event(hkrd_pkg::EV_RELEASE, scan_map[held_codes[i]]);
              end
            end
          end
          for (int i = 0; i < KS; i++) begin
            if (now_codes[i] != '0) begin
              found = 1'b0;
              for (int j = 0; j < KS; j++) begin
                if (held_codes[j] == now_codes[i]) found = 1'b1;
              end
              if (!found && scan_map[now_codes[i]] != hkrd_pkg::UNMAPPED) begin
                add_event(hkrd_pkg::EV_PRESS, scan_map[now_codes[i]]);
              end
            end
          end
          // unmapped codes are still remembered
          held_codes = now_codes;
        end
      end
      default: begin
        // unused op: no effect at all
      end
    endcase
    if (fresh_events.size() > 0) begin
      tail = fresh_events.pop_back();
      tail.last = 1'b1;
      fresh_events.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  // random fill, so that don't-care fields toggle too
  function automatic hkrd_pkg::in_word_t junk_word();
    logic [95:0] bits_r;
    bits_r = {$urandom, $urandom, $urandom};
    return hkrd_pkg::in_word_t'(bits_r[IN_W-1:0]);
  endfunction

  // keys packed slot 0 first: 48'h04_05_06_07_08_09
  function automatic hkrd_pkg::in_word_t report_w(logic [7:0] mods,
                                                  logic [6*CW-1:0] keys);
    hkrd_pkg::in_word_t w;
    w = junk_word();
    w.op = hkrd_pkg::OP_REPORT;
    w.modifiers = mods;
    {w.key0, w.key1, w.key2, w.key3, w.key4, w.key5} = keys;
    return w;
  endfunction

  function automatic hkrd_pkg::in_word_t map_w(logic [7:0] idx, logic [7:0] val);
    hkrd_pkg::in_word_t w;
    w = junk_word();
    w.op = hkrd_pkg::OP_MAP_WRITE;
    w.map_index = idx;
    w.map_value = val;
    return w;
  endfunction

  function automatic hkrd_pkg::in_word_t bare_w(hkrd_pkg::op_t op);
    hkrd_pkg::in_word_t w;
    w = junk_word();
    w.op = op;
    return w;
  endfunction

  // small code pool keeps keys held across reports so the diff has work to do
  logic [7:0] key_pool [10] = '{8'h04, 8'h05, 8'h06, 8'h07, 8'h1E,
                                8'h2C, 8'h4C, 8'hE0, 8'hFF, 8'h39};

  function automatic logic [7:0] pool_code();
    return key_pool[$urandom_range(0, 9)];
  endfunction

  function automatic hkrd_pkg::in_word_t random_word();
    hkrd_pkg::in_word_t    w;
    int                    pick;
    logic [KS-1:0][CW-1:0] k;
    w = junk_word();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      w.op = hkrd_pkg::OP_UNUSED;
    end else if (pick < 10) begin
      w.op = hkrd_pkg::OP_DISCONNECT;
    end else if (pick < 25) begin
      w.op = hkrd_pkg::OP_MAP_WRITE;
      if ($urandom_range(0, 4) != 0) w.map_index = pool_code();
      if ($urandom_range(0, 6) == 0) w.map_value = hkrd_pkg::UNMAPPED;
    end else begin
      w.op = hkrd_pkg::OP_REPORT;
      for (int i = 0; i < KS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) k[i] = '0;
        else if (pick < 90) k[i] = pool_code();
        else k[i] = CW'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        w.modifiers = 8'($urandom_range(0, 255));
      end else if (pick < 90) begin
        w.modifiers = 8'($urandom_range(0, 255)) & hkrd_pkg::MOD_SHIFT;
      end else begin
        // well-formed reset chord
        w.modifiers = 8'($urandom_range(0, 255))
                    | ($urandom_range(0, 1) ? 8'h01 : 8'h10)
                    | ($urandom_range(0, 1) ? 8'h04 : 8'h40);
        k[$urandom_range(0, KS - 1)] = hkrd_pkg::CODE_DELETE;
      end
      {w.key0, w.key1, w.key2, w.key3, w.key4, w.key5} = k;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Report side: drive a word, hold it through stall, log expectations on accept
  // --------------------------------------------------------------------------
  task automatic send_word(hkrd_pkg::in_word_t w, row_chk_t chk, hkrd_pkg::ev_t one_ev);
    hkrd_pkg::out_word_t typed;
    rpt       <= w;
    rpt_valid <= 1'b1;
    do @(posedge clk); while (rpt_stall);
    // accepted at this edge; engine state moves on for typed rows too
    diff_report(w);
    case (chk)
      ROW_PREDICTED: begin
        foreach (fresh_events[i]) expected_events.push_back(fresh_events[i]);
      end
      ROW_ONE_EVENT: begin
        typed.event_res = one_ev;
        typed.scan_code = '0;
        typed.last      = 1'b1;
        expected_events.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      rpt_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Event side: random stall bursts, each a random run of stall cycles
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst || calm) begin
      evt_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      evt_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      evt_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      evt_stall <= 1'b0;
    end
  end

  task automatic flag_error(string msg);
    if (err_count < 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // event word checker, samples pre-edge values
  hkrd_pkg::out_word_t oldest_evt;

  always @(posedge clk) begin
    if (!rst && evt_valid && !evt_stall) begin
      if (expected_events.size() == 0) begin
        flag_error($sformatf("unexpected word: event %0d scan %02h last %0b",
                             evt.event_res, evt.scan_code, evt.last));
      end else begin
        oldest_evt = expected_events.pop_front();
        if (evt.event_res !== oldest_evt.event_res)
          flag_error($sformatf("event_res %0d, want %0d",
                               evt.event_res, oldest_evt.event_res));
        if (evt.scan_code !== oldest_evt.scan_code)
          flag_error($sformatf("scan_code %02h, want %02h",
                               evt.scan_code, oldest_evt.scan_code));
        if (evt.last !== oldest_evt.last)
          flag_error($sformatf("last %0b, want %0b", evt.last, oldest_evt.last));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  step_row_t dir_rows[$];

  function automatic void add_row(hkrd_pkg::in_word_t w, row_chk_t chk,
                                  hkrd_pkg::ev_t one_ev);
    step_row_t r;
    r.w      = w;
    r.chk    = chk;
    r.one_ev = one_ev;
    dir_rows.push_back(r);
  endfunction

  initial begin
    clear_keys();
    foreach (scan_map[i]) scan_map[i] = hkrd_pkg::UNMAPPED;

    // empty report straight out of reset changes nothing
    add_row(report_w(8'h00, 48'h0), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    // right shift alone, then released
    add_row(report_w(8'h20, 48'h0), ROW_ONE_EVENT, hkrd_pkg::EV_SHIFT_DOWN);
    add_row(report_w(8'h00, 48'h0), ROW_ONE_EVENT, hkrd_pkg::EV_SHIFT_UP);
    // unmapped keys: silent but remembered
    add_row(report_w(8'h00, 48'h04_05_06_07_08_09), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    add_row(map_w(8'h04, 8'h1E), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    add_row(map_w(8'h05, 8'h30), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    add_row(map_w(8'h4C, 8'h53), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    add_row(map_w(8'hFF, 8'h00), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    add_row(map_w(8'h00, 8'hAA), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    add_row(map_w(8'h06, 8'hFE), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    // shift down, unmapped releases dropped, 0xFF maps to scan 0
    add_row(report_w(8'h22, 48'h04_05_06_FF_00_00), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    // repeated codes in one report
    add_row(report_w(8'h00, 48'h05_05_04_00_00_00), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    // Delete without the chord is an ordinary key
    add_row(report_w(8'h00, 48'h4C_00_00_00_00_00), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    // reset chord, Delete in the last slot, then in the first slot
    add_row(report_w(8'h55, 48'h00_00_00_00_00_4C), ROW_ONE_EVENT,
            hkrd_pkg::EV_MACHINE_RESET);
    add_row(report_w(8'h14, 48'h4C_00_00_00_00_00), ROW_ONE_EVENT,
            hkrd_pkg::EV_MACHINE_RESET);
    // ctrl only, alt only: not a chord
    add_row(report_w(8'h11, 48'h4C_00_00_00_00_00), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    add_row(report_w(8'h44, 48'h04_05_06_4C_FF_00), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    add_row(bare_w(hkrd_pkg::OP_DISCONNECT), ROW_ONE_EVENT, hkrd_pkg::EV_RELEASE_ALL);
    add_row(bare_w(hkrd_pkg::OP_UNUSED), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);
    // all modifiers without Delete, six copies of one key
    add_row(report_w(8'hFF, 48'h04_04_04_04_04_04), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    // longest burst: shift up, six releases, six presses
    add_row(report_w(8'h00, 48'hFF_FF_FF_FF_FF_FF), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    add_row(bare_w(hkrd_pkg::OP_DISCONNECT), ROW_ONE_EVENT, hkrd_pkg::EV_RELEASE_ALL);
    add_row(map_w(8'hFF, 8'hFF), ROW_NO_RESULT, hkrd_pkg::EV_PRESS);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      sender_gap();
      send_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].one_ev);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 100) begin
        // hold off until the block has drained everything owed
        rpt_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_WORDS - 40) quiet = 1'b1;
      sender_gap();
      send_word(random_word(), ROW_PREDICTED, hkrd_pkg::EV_PRESS);
    end
    rpt_valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    // catch stray words after the last expected one
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
